// ===== rtl/csa_pkg.sv =====
// Shared constants, arctangent table and stage types for the CORDIC core.
`timescale 1ns / 1ps

package csa_pkg;

    localparam int ITERATIONS   = 24;
    localparam int ATAN_ENTRIES = 31;
    localparam int N_ITER       = (ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : ITERATIONS;

    // datapath widths: x/y carry CORDIC gain and sqrt(2) growth, z holds a turn plus margin
    localparam int XW = 36;
    localparam int ZW = 34;

    localparam logic [31:0] CORDIC_K     = 32'd1304065748;
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

    localparam logic [31:0] ATAN_TAB [ATAN_ENTRIES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001
    };

    typedef struct packed {
        logic                 op;    // 0: sin/cos, 1: phase
        logic                 neg;   // sin/cos angle was turned by half a turn
        logic                 zero;  // phase of the zero vector
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } stage_t;

    typedef struct packed {
        logic [31:0] cos_out;
        logic [31:0] sin_out;
        logic [31:0] phase_out;
    } res_t;

endpackage

// ===== rtl/csa_prep.sv =====
// Input register, quadrant reduction, vector normalization and left half plane pre-rotation.
`timescale 1ns / 1ps

module csa_prep (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 ce,
    input  logic                 in_valid,
    input  logic                 op,
    input  logic [31:0]          angle,
    input  logic signed [31:0]   x_in,
    input  logic signed [31:0]   y_in,
    output logic                 out_valid,
    output csa_pkg::stage_t      out_data
);

    localparam int XW = csa_pkg::XW;
    localparam int ZW = csa_pkg::ZW;

    logic [3:0]       v_reg;
    csa_pkg::stage_t  d1_reg, d2_reg, d3_reg, d4_reg;
    csa_pkg::stage_t  d1_next, d2_next, d3_next, d4_next;
    logic [31:0]      m1_reg, m2_reg;
    logic [31:0]      m1_next, m2_next;

    // stage 1: reduction for sin/cos, magnitude and zero test for phase
    always_comb begin
        logic [31:0]        ang_r;
        logic signed [32:0] xs, ys, ax, ay;
        logic               neg;
        neg   = (angle[31:30] == 2'b01) || (angle[31:30] == 2'b10);
        ang_r = neg ? {~angle[31], angle[30:0]} : angle;
        xs    = {x_in[31], x_in};
        ys    = {y_in[31], y_in};
        ax    = xs[32] ? -xs : xs;
        ay    = ys[32] ? -ys : ys;
        m1_next = (ax > ay) ? ax[31:0] : ay[31:0];
        d1_next.op   = op;
        d1_next.neg  = !op && neg;
        d1_next.zero = op && (x_in == '0) && (y_in == '0);
        if (op) begin
            d1_next.x = {{(XW-32){x_in[31]}}, x_in};
            d1_next.y = {{(XW-32){y_in[31]}}, y_in};
            d1_next.z = '0;
        end else begin
            d1_next.x = {{(XW-32){1'b0}}, csa_pkg::CORDIC_K};
            d1_next.y = '0;
            d1_next.z = {{(ZW-32){ang_r[31]}}, ang_r};
        end
    end

    // stage 2: normalize by 16 and 8
    always_comb begin
        logic [31:0] m;
        d2_next = d1_reg;
        m       = m1_reg;
        if (d1_reg.op && m[31:15] == '0) begin
            m         = m << 16;
            d2_next.x = d2_next.x <<< 16;
            d2_next.y = d2_next.y <<< 16;
        end
        if (d1_reg.op && m[31:23] == '0) begin
            m         = m << 8;
            d2_next.x = d2_next.x <<< 8;
            d2_next.y = d2_next.y <<< 8;
        end
        m2_next = m;
    end

    // stage 3: normalize by 4, 2 and 1 until the larger magnitude reaches 2^30
    always_comb begin
        logic [31:0] m;
        d3_next = d2_reg;
        m       = m2_reg;
        if (d2_reg.op && m[31:27] == '0) begin
            m         = m << 4;
            d3_next.x = d3_next.x <<< 4;
            d3_next.y = d3_next.y <<< 4;
        end
        if (d2_reg.op && m[31:29] == '0) begin
            m         = m << 2;
            d3_next.x = d3_next.x <<< 2;
            d3_next.y = d3_next.y <<< 2;
        end
        if (d2_reg.op && m[31:30] == '0) begin
            d3_next.x = d3_next.x <<< 1;
            d3_next.y = d3_next.y <<< 1;
        end
    end

    // stage 4: quarter-turn pre-rotation of left half plane vectors
    always_comb begin
        d4_next = d3_reg;
        if (d3_reg.op && d3_reg.x[XW-1]) begin
            if (!d3_reg.y[XW-1]) begin
                d4_next.x = d3_reg.y;
                d4_next.y = -d3_reg.x;
                d4_next.z = {{(ZW-32){1'b0}}, csa_pkg::QUARTER_TURN};
            end else begin
                d4_next.x = -d3_reg.y;
                d4_next.y = d3_reg.x;
                d4_next.z = -{{(ZW-32){1'b0}}, csa_pkg::QUARTER_TURN};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d1_reg <= d1_next;
            d2_reg <= d2_next;
            d3_reg <= d3_next;
            d4_reg <= d4_next;
            m1_reg <= m1_next;
            m2_reg <= m2_next;
        end
    end

    assign out_valid = v_reg[3];
    assign out_data  = d4_reg;

endmodule

// ===== rtl/csa_rotator.sv =====
// Unrolled CORDIC micro-rotation pipeline, one shift-add stage per iteration.
`timescale 1ns / 1ps

module csa_rotator (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             ce,
    input  logic             in_valid,
    input  csa_pkg::stage_t  in_data,
    output logic             out_valid,
    output csa_pkg::stage_t  out_data
);

    localparam int N  = csa_pkg::N_ITER;
    localparam int XW = csa_pkg::XW;
    localparam int ZW = csa_pkg::ZW;

    logic [N-1:0]     v_reg;
    csa_pkg::stage_t  d_reg [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        csa_pkg::stage_t src;
        logic            src_v;
        csa_pkg::stage_t d_next;

        if (k == 0) begin : g_first
            assign src   = in_data;
            assign src_v = in_valid;
        end else begin : g_chain
            assign src   = d_reg[k-1];
            assign src_v = v_reg[k-1];
        end

        always_comb begin
            logic signed [XW-1:0] dx, dy;
            logic signed [ZW-1:0] a;
            logic                 ccw;
            dx  = src.y >>> k;
            dy  = src.x >>> k;
            a   = {{(ZW-32){1'b0}}, csa_pkg::ATAN_TAB[k]};
            // rotation mode steers by sign of z, vectoring mode by sign of y
            ccw = src.op ? src.y[XW-1] : !src.z[ZW-1];
            d_next = src;
            if (ccw) begin
                d_next.x = src.x - dx;
                d_next.y = src.y + dy;
                d_next.z = src.z - a;
            end else begin
                d_next.x = src.x + dx;
                d_next.y = src.y - dy;
                d_next.z = src.z + a;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (ce) begin
                v_reg[k] <= src_v;
            end
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                d_reg[k] <= d_next;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_data  = d_reg[N-1];

endmodule

// ===== rtl/csa_post.sv =====
// Result stage: undo the half-turn reduction, saturate to q1.31, select phase.
`timescale 1ns / 1ps

module csa_post (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             ce,
    input  logic             in_valid,
    input  csa_pkg::stage_t  in_data,
    output logic             out_valid,
    output csa_pkg::res_t    out_data
);

    localparam int XW = csa_pkg::XW;

    logic          v_reg;
    csa_pkg::res_t r_reg, r_next;

    function automatic logic [31:0] sat32(input logic signed [XW-1:0] v);
        // in range when every bit above bit 30 matches the sign
        if (!v[XW-1] && v[XW-2:31] != '0) begin
            return 32'h7FFF_FFFF;
        end else if (v[XW-1] && v[XW-2:31] != '1) begin
            return 32'h8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    always_comb begin
        logic signed [XW-1:0] xc, yc;
        xc = in_data.neg ? -in_data.x : in_data.x;
        yc = in_data.neg ? -in_data.y : in_data.y;
        if (in_data.op) begin
            r_next.cos_out   = '0;
            r_next.sin_out   = '0;
            r_next.phase_out = in_data.zero ? '0 : in_data.z[31:0];
        end else begin
            r_next.cos_out   = sat32(xc);
            r_next.sin_out   = sat32(yc);
            r_next.phase_out = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (ce) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            r_reg <= r_next;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = r_reg;

endmodule

// ===== rtl/cordic_sincos_atan2_core.sv =====
// Stages from input transfer to m_valid:
//   4 preprocessing stages, one stage per micro-rotation, a result stage, the output register.
// Throughput: one item per cycle while s_ready is high; every micro-rotation has its own
// shift-add stage. A skid register catches the one result that arrives after the output
// stalls; s_ready then drops and the pipeline holds until the output register frees.
// Reset: synchronous, active-low aresetn clears all valid bits; s_ready is high after reset.
`timescale 1ns / 1ps

module cordic_sincos_atan2_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_op,
    input  logic [31:0]         s_angle,
    input  logic signed [31:0]  s_x_in,
    input  logic signed [31:0]  s_y_in,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_cos_out,
    output logic signed [31:0]  m_sin_out,
    output logic [31:0]         m_phase_out
);

    logic             ce;
    logic             prep_valid, rot_valid, post_valid;
    csa_pkg::stage_t  prep_data, rot_data;
    csa_pkg::res_t    post_data;

    logic             m_valid_reg, m_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    csa_pkg::res_t    out_reg, out_next;
    csa_pkg::res_t    skid_reg, skid_next;

    // pipeline advances whenever the skid register is empty
    assign ce      = !skid_valid_reg;
    assign s_ready = ce;

    csa_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_valid),
        .op        (s_op),
        .angle     (s_angle),
        .x_in      (s_x_in),
        .y_in      (s_y_in),
        .out_valid (prep_valid),
        .out_data  (prep_data)
    );

    csa_rotator u_rot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (prep_valid),
        .in_data   (prep_data),
        .out_valid (rot_valid),
        .out_data  (rot_data)
    );

    csa_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (rot_valid),
        .in_data   (rot_data),
        .out_valid (post_valid),
        .out_data  (post_data)
    );

    always_comb begin
        logic out_free;
        out_free        = !m_valid_reg || m_ready;
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (out_free) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                m_valid_next    = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next     = post_data;
                m_valid_next = post_valid;
            end
        end else if (post_valid && !skid_valid_reg) begin
            skid_next       = post_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_cos_out   = out_reg.cos_out;
    assign m_sin_out   = out_reg.sin_out;
    assign m_phase_out = out_reg.phase_out;

endmodule

// ===== rtl/csa_checker.sv =====
// Port-level checker for the CORDIC core and its bind to the top level.
`timescale 1ns / 1ps

module csa_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_valid,
    input logic         s_ready,
    input logic         s_op,
    input logic [31:0]  s_angle,
    input logic [31:0]  s_x_in,
    input logic [31:0]  s_y_in,
    input logic         m_valid,
    input logic         m_ready,
    input logic [31:0]  m_cos_out,
    input logic [31:0]  m_sin_out,
    input logic [31:0]  m_phase_out
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cos_out) && $stable(m_sin_out)
            && $stable(m_phase_out))
        else $error("result changed or dropped while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("valid result or back-pressure right after reset");

    // input side only backs up after the output was stalled
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> $past(m_valid && !m_ready))
        else $error("input stalled without output back-pressure");

    a_ready_recover: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |=> s_ready)
        else $error("input still stalled after output was free");

    // a result is either sine/cosine or phase, never both
    a_result_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_phase_out == '0) || (m_cos_out == '0 && m_sin_out == '0))
        else $error("result mixes sine/cosine and phase");

endmodule

bind cordic_sincos_atan2_core csa_checker u_csa_checker (.*);

// ===== test/testbench.sv =====
// Self-checking testbench for the CORDIC sine/cosine and phase core.
`timescale 1ns / 1ps

class cordic_tracker;
    csa_pkg::res_t awaited_results[$];
    int errors;
    int checked;

    function new();
        errors  = 0;
        checked = 0;
    endfunction

    function logic [31:0] sat_q31(longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function csa_pkg::res_t calc_sincos(logic [31:0] ang);
        csa_pkg::res_t r;
        longint x, y, z, dx, dy;
        logic [31:0] a;
        bit neg;
        // second and third quadrant: rotate by half a turn, negate at the end
        neg = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
        a = neg ? ang + csa_pkg::HALF_TURN : ang;
        z = longint'($signed(a));
        x = longint'(csa_pkg::CORDIC_K);
        y = 0;
        for (int i = 0; i < csa_pkg::N_ITER; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(csa_pkg::ATAN_TAB[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(csa_pkg::ATAN_TAB[i]);
            end
        end
        if (neg) begin
            x = -x;
            y = -y;
        end
        r.cos_out   = sat_q31(x);
        r.sin_out   = sat_q31(y);
        r.phase_out = 32'd0;
        return r;
    endfunction

    function csa_pkg::res_t calc_phase(logic signed [31:0] xi, logic signed [31:0] yi);
        csa_pkg::res_t r;
        longint x, y, ax, ay, m, t, dx, dy;
        logic [31:0] z;
        x = xi;
        y = yi;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        m = (ax > ay) ? ax : ay;
        z = 32'd0;
        r.cos_out = 32'd0;
        r.sin_out = 32'd0;
        if (m != 0) begin
            while (m < longint'(csa_pkg::QUARTER_TURN)) begin
                m = m * 2;
                x = x * 2;
                y = y * 2;
            end
            // left half plane: pre-rotate by a quarter turn into the right half
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y;
                    y = -t;
                    z = csa_pkg::QUARTER_TURN;
                end else begin
                    x = -y;
                    y = t;
                    z = 32'd0 - csa_pkg::QUARTER_TURN;
                end
            end
            for (int i = 0; i < csa_pkg::N_ITER; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + csa_pkg::ATAN_TAB[i];
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - csa_pkg::ATAN_TAB[i];
                end
            end
        end
        r.phase_out = z;
        return r;
    endfunction

    function void note_request(logic op, logic [31:0] ang,
                               logic signed [31:0] xi, logic signed [31:0] yi);
        if (op == 1'b1)
            awaited_results.push_back(calc_phase(xi, yi));
        else
            awaited_results.push_back(calc_sincos(ang));
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("%0t: result %0d %s: got %h, expected %h", $time, checked, what, got, want);
    endtask

    task check_answer(logic [31:0] cos_v, logic [31:0] sin_v, logic [31:0] phase_v);
        csa_pkg::res_t want;
        if (awaited_results.size() == 0) begin
            report_mismatch("arrived with no request pending", phase_v, 32'd0);
        end else begin
            want = awaited_results.pop_front();
            if (cos_v !== want.cos_out)
                report_mismatch("cos_out", cos_v, want.cos_out);
            if (sin_v !== want.sin_out)
                report_mismatch("sin_out", sin_v, want.sin_out);
            if (phase_v !== want.phase_out)
                report_mismatch("phase_out", phase_v, want.phase_out);
        end
        checked++;
    endtask
endclass

module testbench;

    localparam logic OP_SINCOS = 1'b0;
    localparam logic OP_PHASE  = 1'b1;

    localparam int RANDOM_ITEMS = 1430;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = csa_pkg::ITERATIONS + 16;

    localparam logic signed [31:0] Q31_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q31_MIN = 32'sh8000_0000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_op = 1'b0;
    logic [31:0]        s_angle = 32'd0;
    logic signed [31:0] s_x_in = 32'sd0;
    logic signed [31:0] s_y_in = 32'sd0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_cos_out;
    logic signed [31:0] m_sin_out;
    logic [31:0]        m_phase_out;

    cordic_tracker tracker = new();
    int  quiet_cycles = 0;
    bit  tx_calm = 1'b0;

    cordic_sincos_atan2_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_angle     (s_angle),
        .s_x_in      (s_x_in),
        .s_y_in      (s_y_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cos_out   (m_cos_out),
        .m_sin_out   (m_sin_out),
        .m_phase_out (m_phase_out)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(input logic op, input logic [31:0] ang,
                             input logic signed [31:0] xv, input logic signed [31:0] yv);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_angle <= ang;
        s_x_in  <= xv;
        s_y_in  <= yv;
        do @(posedge aclk); while (!s_ready);
        tracker.note_request(op, ang, xv, yv);
    endtask

    task automatic send_sincos(input logic [31:0] ang);
        send_item(OP_SINCOS, ang, $urandom, $urandom);
    endtask

    task automatic send_phase(input logic signed [31:0] xv, input logic signed [31:0] yv);
        send_item(OP_PHASE, $urandom, xv, yv);
    endtask

    // angles cluster around quadrant edges now and then, where the reduction flips
    function automatic logic [31:0] rand_angle();
        logic [31:0] base;
        if ($urandom_range(0, 3) == 0) begin
            base = {2'($urandom_range(0, 3)), 30'd0};
            return base + $urandom_range(0, 64) - 32'd32;
        end
        return $urandom;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        logic signed [31:0] v;
        int r;
        r = $urandom_range(0, 99);
        v = $urandom;
        if (r < 6)
            return 32'sd0;
        if (r < 12) begin
            case ($urandom_range(0, 3))
                0: v = Q31_MAX;
                1: v = Q31_MIN;
                2: v = 32'sd1;
                default: v = -32'sd1;
            endcase
        end
        return v;
    endfunction

    task automatic send_random_phase();
        logic signed [31:0] xv, yv;
        int sh;
        xv = rand_coord();
        yv = rand_coord();
        if ($urandom_range(0, 49) == 0) begin
            xv = 32'sd0;
            yv = 32'sd0;
        end else if ($urandom_range(0, 1) == 0) begin
            // small vectors exercise the normalization shifts
            sh = $urandom_range(1, 31);
            xv = xv >>> sh;
            yv = yv >>> sh;
        end
        send_phase(xv, yv);
    endtask

    // receiver: calm stretches alternate with random and long stalls
    initial begin
        int rx_left;
        int len;
        bit rx_calm;
        rx_left = 0;
        rx_calm = 1'b0;
        wait (aresetn);
        forever begin
            if (rx_left <= 0) begin
                rx_calm = ($urandom_range(0, 2) == 0);
                rx_left = 250;
            end
            if (rx_calm) begin
                m_ready <= 1'b1;
                @(posedge aclk);
                rx_left--;
            end else if ($urandom_range(0, 99) < 3) begin
                len = $urandom_range(15, 60);
                m_ready <= 1'b0;
                repeat (len) @(posedge aclk);
                rx_left -= len;
            end else begin
                m_ready <= ($urandom_range(0, 99) < 70);
                @(posedge aclk);
                rx_left--;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_answer(m_cos_out, m_sin_out, m_phase_out);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // quadrant edges and their neighbors
        send_sincos(32'h0000_0000);
        send_sincos(32'h2000_0000);
        send_sincos(32'h3FFF_FFFF);
        send_sincos(32'h4000_0000);
        send_sincos(32'h7FFF_FFFF);
        send_sincos(32'h8000_0000);
        send_sincos(32'h8000_0001);
        send_sincos(32'hBFFF_FFFF);
        send_sincos(32'hC000_0000);
        send_sincos(32'hFFFF_FFFF);

        // zero vector, axes, full-scale corners, tiny vectors, both left-half cases
        send_phase(32'sd0, 32'sd0);
        send_phase(Q31_MAX, 32'sd0);
        send_phase(Q31_MIN, 32'sd0);
        send_phase(32'sd0, Q31_MIN);
        send_phase(32'sd0, Q31_MAX);
        send_phase(Q31_MIN, Q31_MIN);
        send_phase(Q31_MAX, Q31_MAX);
        send_phase(Q31_MIN, -32'sd1);
        send_phase(32'sd1, 32'sd0);
        send_phase(-32'sd1, -32'sd1);
        send_phase(32'sd0, 32'sd1);
        send_phase(32'sd1, -32'sd1);
        send_phase(-32'sd5, 32'sd3);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 200 == 0)
                tx_calm = ($urandom_range(0, 2) == 0);
            if (n == RANDOM_ITEMS / 2) begin
                // hold off until the pipeline has fully drained
                s_valid <= 1'b0;
                @(posedge aclk);
                while (tracker.awaited_results.size() != 0) @(posedge aclk);
            end
            if ($urandom_range(0, 1) == 0)
                send_sincos(rand_angle());
            else
                send_random_phase();
        end
        s_valid <= 1'b0;

        while (tracker.awaited_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (tracker.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
